FILE: sv/sorted_interval_lookup_table_macros.svh
// Assertion macros of the checker file of the zone table.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef SORTED_INTERVAL_LOOKUP_TABLE_MACROS_SVH
`define SORTED_INTERVAL_LOOKUP_TABLE_MACROS_SVH

// Same-cycle implication under reset.
`define SILT_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under reset.
`define SILT_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/silt_pkg.sv
// Package of the sorted interval lookup table: sizes, table entry and
// transaction types, status codes, controller states and the midpoint helper.
// No dependencies.
package silt_pkg;

	localparam int ZONE_DEPTH = 512;
	localparam int AW = $clog2(ZONE_DEPTH);
	localparam int CW = $clog2(ZONE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(ZONE_DEPTH);

	typedef struct packed {
		logic [31:0] start;
		logic [31:0] len;
		logic [15:0] id;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [1:0] {
		ST_LOADED = 2'd0,
		ST_FULL   = 2'd1,
		ST_HIT    = 2'd2,
		ST_MISS   = 2'd3
	} status_t;

	typedef enum logic {
		MODE_LOAD   = 1'b0,
		MODE_LOOKUP = 1'b1
	} mode_t;

	typedef struct packed {
		logic        mode;
		logic [15:0] zone_id;
		logic [31:0] offset;
		logic [31:0] length;
		logic [15:0] tag;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] found_zone;
		logic [15:0] tag_out;
		logic [31:0] offset_out;
	} res_t;

	typedef struct packed {
		logic                re;
		logic [AW-1:0]       raddr;
		logic                we;
		logic [AW-1:0]       waddr;
		logic [ENTRY_W-1:0]  wdata;
	} ram_req_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PROBE,
		S_LREAD,
		S_LSHIFT,
		S_OUT
	} state_t;

	function automatic logic [AW-1:0] mid_of(logic [CW-1:0] a, logic [CW-1:0] b);
		logic [CW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return AW'(s >> 1);
	endfunction

endpackage

FILE: sv/silt_item_if.sv
// Input channel of the zone table: valid/ready handshake with the item payload.
// No dependencies.
interface silt_item_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [15:0] zone_id;
	logic [31:0] offset;
	logic [31:0] length;
	logic [15:0] tag;

	modport source (output valid, output mode, output zone_id, output offset,
		output length, output tag, input ready);
	modport sink (input valid, input mode, input zone_id, input offset,
		input length, input tag, output ready);
endinterface

FILE: sv/silt_result_if.sv
// Result channel of the zone table: valid/ready handshake with the result payload.
// No dependencies.
interface silt_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] found_zone;
	logic [15:0] tag_out;
	logic [31:0] offset_out;

	modport source (output valid, output status, output found_zone,
		output tag_out, output offset_out, input ready);
	modport sink (input valid, input status, input found_zone,
		input tag_out, input offset_out, output ready);
endinterface

FILE: sv/silt_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module silt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

FILE: sv/silt_ctrl.sv
// Sequencer of the zone table: sorted insertion by shifting entries up and
// binary search with one probe per cycle. Depends on silt_pkg.
module silt_ctrl import silt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  item_t    item,
	output logic     res_valid,
	input  logic     res_ready,
	output res_t     res,
	output ram_req_t ram_req,
	input  entry_t   rd_entry
);
	state_t        state_q, state_d;
	logic [CW-1:0] count_q;
	logic [CW-1:0] lo_q, hi_q;
	logic [AW-1:0] idx_q;
	item_t         item_q;
	res_t          res_q;

	logic          accept;
	logic [32:0]   end_w;
	logic          hit;
	logic          below;
	logic [CW-1:0] nlo, nhi;
	logic [AW-1:0] nmid;
	logic          more;
	logic          move_up;
	entry_t        new_entry;

	assign accept = item_valid && item_ready;

	assign end_w = {1'b0, rd_entry.start} + {1'b0, rd_entry.len};
	assign hit   = (item_q.offset >= rd_entry.start) && ({1'b0, item_q.offset} < end_w);
	assign below = item_q.offset < rd_entry.start;
	assign nlo   = below ? lo_q : CW'(idx_q) + CW'(1);
	assign nhi   = below ? CW'(idx_q) : hi_q;
	assign nmid  = mid_of(nlo, nhi);
	assign more  = nlo < nhi;

	assign move_up   = rd_entry.start > item_q.offset;
	assign new_entry = '{start: item_q.offset, len: item_q.length, id: item_q.zone_id};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (item.mode == MODE_LOOKUP) begin
						state_d = (count_q == '0) ? S_OUT : S_PROBE;
					end else begin
						state_d = (count_q >= DEPTH_C) ? S_OUT : S_LREAD;
					end
				end
			end
			S_PROBE: begin
				if (hit || !more) begin
					state_d = S_OUT;
				end
			end
			S_LREAD: begin
				state_d = (idx_q == '0) ? S_OUT : S_LSHIFT;
			end
			S_LSHIFT: begin
				state_d = move_up ? S_LREAD : S_OUT;
			end
			S_OUT: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		item_ready    = 1'b0;
		res_valid     = 1'b0;
		ram_req.re    = 1'b0;
		ram_req.raddr = '0;
		ram_req.we    = 1'b0;
		ram_req.waddr = idx_q;
		ram_req.wdata = new_entry;
		unique case (state_q)
			S_IDLE: begin
				item_ready    = 1'b1;
				ram_req.re    = item_valid && (item.mode == MODE_LOOKUP) && (count_q != '0);
				ram_req.raddr = mid_of('0, count_q);
			end
			S_PROBE: begin
				ram_req.re    = !hit && more;
				ram_req.raddr = nmid;
			end
			S_LREAD: begin
				ram_req.re    = idx_q != '0;
				ram_req.raddr = idx_q - AW'(1);
				ram_req.we    = idx_q == '0;
			end
			S_LSHIFT: begin
				ram_req.we    = 1'b1;
				ram_req.wdata = move_up ? rd_entry : new_entry;
			end
			S_OUT: begin
				res_valid = 1'b1;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if ((state_q == S_LREAD && idx_q == '0) || (state_q == S_LSHIFT && !move_up)) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					item_q         <= item;
					lo_q           <= '0;
					hi_q           <= count_q;
					res_q.found_zone <= '0;
					res_q.tag_out    <= item.tag;
					res_q.offset_out <= item.offset;
					if (item.mode == MODE_LOOKUP) begin
						idx_q        <= mid_of('0, count_q);
						res_q.status <= ST_MISS;
					end else begin
						idx_q        <= AW'(count_q);
						res_q.status <= (count_q >= DEPTH_C) ? ST_FULL : ST_LOADED;
					end
				end
			end
			S_PROBE: begin
				if (hit) begin
					res_q.status     <= ST_HIT;
					res_q.found_zone <= rd_entry.id;
				end else begin
					lo_q  <= nlo;
					hi_q  <= nhi;
					idx_q <= nmid;
				end
			end
			S_LSHIFT: begin
				if (move_up) begin
					idx_q <= idx_q - AW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign res = res_q;
endmodule

FILE: sv/sorted_interval_lookup_table.sv
// Top level of the sorted interval lookup table.
// Depends on silt_pkg, silt_item_if, silt_result_if, silt_ram and silt_ctrl.
//
// The item channel takes one transaction at a time. A transaction with mode
// load inserts a zone (id, start offset, length) into a table kept sorted by
// start; equal starts keep load order, and a load into a full table is dropped
// with status full. A transaction with mode lookup runs a binary search and
// returns the id of the probed zone whose half-open range holds the offset,
// or status miss. Every item yields exactly one result transaction, which
// echoes the tag and the offset.
// A lookup makes one memory probe per cycle, at most log2(512) + 1 = 10, after the
// item is taken and before the result passes to the output register; the next item
// is taken only after that.
// A load reads and rewrites each entry that moves up, one after the other through
// the single table memory, and then writes the new entry; a load into a full table
// makes no memory access.
// Results sit in an output register; the next item is taken while a result
// waits there, and a stalled receiver holds the block only once a second
// result is ready. Reset empties the table at once and needs no clearing pass.
module sorted_interval_lookup_table import silt_pkg::*; (
	input logic           clk,
	input logic           arst_n,
	silt_item_if.sink     item,
	silt_result_if.source result
);
	item_t    item_w;
	res_t     res_w;
	logic     res_valid;
	logic     res_ready;
	ram_req_t ram_req;
	entry_t   rd_entry;
	logic     out_valid_q;
	res_t     out_q;

	assign item_w = '{mode: item.mode, zone_id: item.zone_id, offset: item.offset,
		length: item.length, tag: item.tag};

	silt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (ZONE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (rd_entry)
	);

	silt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.item       (item_w),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res_w),
		.ram_req    (ram_req),
		.rd_entry   (rd_entry)
	);

	assign res_ready = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res_w;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.status     = out_q.status;
	assign result.found_zone = out_q.found_zone;
	assign result.tag_out    = out_q.tag_out;
	assign result.offset_out = out_q.offset_out;
endmodule

FILE: sv/silt_checker.sv
// Port-level checks of the sorted interval lookup table, bound to the top level.
// Depends on silt_pkg and sorted_interval_lookup_table_macros.svh.
`include "sorted_interval_lookup_table_macros.svh"

module silt_checker import silt_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic [1:0]  status,
	input logic [15:0] found_zone,
	input logic [15:0] tag_out,
	input logic [31:0] offset_out
);
	// The block works on one transaction at a time.
	`SILT_ASSERT_NEXT(a_one_item_at_a_time, item_valid && item_ready, !item_ready, "item ready stayed high after a transaction")
	// Only a hit carries a zone id.
	`SILT_ASSERT_NOW(a_zone_only_on_hit, result_valid && status != ST_HIT, found_zone == 16'd0, "zone id set on a result that is not a hit")
	`SILT_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid && $stable(status) && $stable(found_zone) && $stable(tag_out) && $stable(offset_out), "stalled result changed")
endmodule

bind sorted_interval_lookup_table silt_checker u_silt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.status       (result.status),
	.found_zone   (result.found_zone),
	.tag_out      (result.tag_out),
	.offset_out   (result.offset_out)
);

FILE: tb/sv/tb_sorted_interval_lookup_table.sv
// Self-checking testbench of the sorted interval lookup table: directed and random
// load and lookup transactions, checked against a scoreboard that keeps its own zone table.
// Depends on silt_pkg, silt_item_if, silt_result_if and sorted_interval_lookup_table.
module tb_sorted_interval_lookup_table;
	import silt_pkg::*;

	class zone_directory;
		logic [31:0] starts [ZONE_DEPTH];
		logic [31:0] lens [ZONE_DEPTH];
		logic [15:0] ids [ZONE_DEPTH];
		int count;
		int errors;
		res_t pending [$];

		function new();
			count = 0;
			errors = 0;
		endfunction

		function void note_item(item_t it);
			res_t r;
			int pos;
			int lo;
			int hi;
			int mid;
			logic hit;
			logic [32:0] zone_end;
			r.status = ST_LOADED;
			r.found_zone = '0;
			r.tag_out = it.tag;
			r.offset_out = it.offset;
			if (it.mode == MODE_LOAD) begin
				if (count >= ZONE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					pos = count;
					while (pos > 0 && starts[pos-1] > it.offset)
						pos--;
					for (int i = count; i > pos; i--) begin
						starts[i] = starts[i-1];
						lens[i] = lens[i-1];
						ids[i] = ids[i-1];
					end
					starts[pos] = it.offset;
					lens[pos] = it.length;
					ids[pos] = it.zone_id;
					count++;
				end
			end else begin
				r.status = ST_MISS;
				lo = 0;
				hi = count;
				hit = 1'b0;
				while (lo < hi && !hit) begin
					mid = (lo + hi) >> 1;
					zone_end = {1'b0, starts[mid]} + {1'b0, lens[mid]};
					if (it.offset >= starts[mid] && {1'b0, it.offset} < zone_end) begin
						hit = 1'b1;
						r.status = ST_HIT;
						r.found_zone = ids[mid];
					end else if (it.offset < starts[mid]) begin
						hi = mid;
					end else begin
						lo = mid + 1;
					end
				end
			end
			pending.push_back(r);
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual status %0d tag %h",
					$time, got.status, got.tag_out);
				errors++;
			end else begin
				want = pending.pop_front();
				if (got.status !== want.status) begin
					$display("%0t: status mismatch, expected %0d, actual %0d",
						$time, want.status, got.status);
					errors++;
				end
				if (got.found_zone !== want.found_zone) begin
					$display("%0t: found_zone mismatch, expected %h, actual %h",
						$time, want.found_zone, got.found_zone);
					errors++;
				end
				if (got.tag_out !== want.tag_out) begin
					$display("%0t: tag_out mismatch, expected %h, actual %h",
						$time, want.tag_out, got.tag_out);
					errors++;
				end
				if (got.offset_out !== want.offset_out) begin
					$display("%0t: offset_out mismatch, expected %h, actual %h",
						$time, want.offset_out, got.offset_out);
					errors++;
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int src_idle = 8;
	int dst_idle = 47;
	zone_directory book;

	silt_item_if item_ch();
	silt_result_if res_ch();

	sorted_interval_lookup_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(res_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		res_ch.ready = ($urandom_range(99) >= dst_idle);
	end

	always @(posedge clk) begin
		res_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.status = status_t'(res_ch.status);
			got.found_zone = res_ch.found_zone;
			got.tag_out = res_ch.tag_out;
			got.offset_out = res_ch.offset_out;
			book.check_result(got);
		end
	end

	task automatic push_item(input logic m, input logic [15:0] id, input logic [31:0] off,
		input logic [31:0] len, input logic [15:0] tg);
		item_t it;
		it.mode = m;
		it.zone_id = id;
		it.offset = off;
		it.length = len;
		it.tag = tg;
		while ($urandom_range(99) < src_idle) begin
			item_ch.valid = 1'b0;
			@(negedge clk);
		end
		item_ch.valid = 1'b1;
		item_ch.mode = it.mode;
		item_ch.zone_id = it.zone_id;
		item_ch.offset = it.offset;
		item_ch.length = it.length;
		item_ch.tag = it.tag;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		book.note_item(it);
		@(negedge clk);
	endtask

	task automatic push_random();
		int k;
		int pick;
		logic [31:0] off;
		logic [31:0] len;
		k = (book.count > 0) ? $urandom_range(book.count - 1) : 0;
		pick = $urandom_range(99);
		if (pick < ((book.count < ZONE_DEPTH) ? 40 : 10)) begin
			pick = $urandom_range(99);
			off = $urandom;
			if (pick < 60) begin
				len = $urandom_range(1 << 20, 1);
			end else if (pick < 75) begin
				len = $urandom;
			end else if (pick < 85) begin
				len = '0;
			end else begin
				len = $urandom_range(4096, 1);
				if (book.count > 0)
					off = book.starts[k];
			end
			push_item(MODE_LOAD, 16'($urandom), off, len, 16'($urandom));
		end else begin
			pick = $urandom_range(99);
			off = $urandom;
			if (book.count > 0) begin
				if (pick < 70)
					off = book.starts[k] + ((book.lens[k] == 0) ? 0 : $urandom % book.lens[k]);
				else if (pick < 80)
					off = book.starts[k] - 1;
				else if (pick < 90)
					off = book.starts[k] + book.lens[k];
			end
			push_item(MODE_LOOKUP, 16'($urandom), off, $urandom, 16'($urandom));
		end
	endtask

	initial begin
		book = new();
		item_ch.valid = 1'b0;
		item_ch.mode = MODE_LOAD;
		item_ch.zone_id = '0;
		item_ch.offset = '0;
		item_ch.length = '0;
		item_ch.tag = '0;
		res_ch.ready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Lookups on an empty table always miss.
		push_item(MODE_LOOKUP, 16'h0000, 32'h0000_0000, 32'h0000_0000, 16'h0000);
		push_item(MODE_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		// The top zone ends past the 32-bit range, and a zero-length zone sits at the bottom.
		push_item(MODE_LOAD, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0001);
		push_item(MODE_LOAD, 16'h0000, 32'h0000_0000, 32'h0000_0000, 16'h0002);
		push_item(MODE_LOAD, 16'h1234, 32'h0000_0100, 32'h0000_0100, 16'h0003);
		push_item(MODE_LOAD, 16'h5678, 32'h0000_0100, 32'h0000_0010, 16'h0004);
		push_item(MODE_LOAD, 16'hABCD, 32'h0000_0080, 32'h0000_0100, 16'h0005);
		push_item(MODE_LOAD, 16'h0001, 32'h0001_0000, 32'h0000_1000, 16'h0006);
		push_item(MODE_LOOKUP, 16'h5555, 32'h0000_0000, 32'h1234_5678, 16'h0007);
		push_item(MODE_LOOKUP, 16'h0000, 32'hFFFF_FFFF, 32'h0000_0000, 16'h0008);
		push_item(MODE_LOOKUP, 16'h0000, 32'hFFFF_FFFE, 32'h0000_0000, 16'h0009);
		push_item(MODE_LOOKUP, 16'h0000, 32'h0000_0100, 32'h0000_0000, 16'h000A);
		push_item(MODE_LOOKUP, 16'h0000, 32'h0000_01FF, 32'h0000_0000, 16'h000B);
		push_item(MODE_LOOKUP, 16'h0000, 32'h0000_0200, 32'h0000_0000, 16'h000C);
		push_item(MODE_LOOKUP, 16'h0000, 32'h0000_007F, 32'h0000_0000, 16'h000D);
		push_item(MODE_LOOKUP, 16'h0000, 32'h0000_0080, 32'h0000_0000, 16'h000E);
		push_item(MODE_LOOKUP, 16'h0000, 32'h0000_0150, 32'h0000_0000, 16'h000F);
		push_item(MODE_LOOKUP, 16'h0000, 32'h0001_0FFF, 32'h0000_0000, 16'h0010);
		push_item(MODE_LOOKUP, 16'h0000, 32'h0001_1000, 32'h0000_0000, 16'h0011);
		push_item(MODE_LOOKUP, 16'h0000, 32'h0005_0000, 32'h0000_0000, 16'h0012);

		// Loads keep coming until the table is full, so later loads are dropped.
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					src_idle = 8;
					dst_idle = 47;
				end
				1: begin
					src_idle = 47;
					dst_idle = 8;
				end
				default: begin
					src_idle = 0;
					dst_idle = 0;
				end
			endcase
			repeat (667) push_random();
		end
		item_ch.valid = 1'b0;

		while (book.pending.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (book.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#70000000;
		$display("simulation failed");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+sv
sv/silt_pkg.sv
sv/silt_item_if.sv
sv/silt_result_if.sv
sv/silt_ram.sv
sv/silt_ctrl.sv
sv/sorted_interval_lookup_table.sv
sv/silt_checker.sv
tb/sv/tb_sorted_interval_lookup_table.sv
